// File: rtl/mtp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mtp_pkg
// Shared types and constants of the touch event to pointer block: event codes,
// field widths, register indexes, state machine types and control structs.
// ----------------------------------------------------------------------------
package mtp_pkg;

  // field widths
  localparam int EVT_W     = 16;
  localparam int VAL_W     = 32;
  localparam int SIZE_W    = 13;
  localparam int ORIENT_W  = 3;
  localparam int MODE_W    = 5;
  localparam int POS_W     = 17;
  localparam int CFG_IDX_W = 8;

  localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

  // event types
  localparam logic [EVT_W-1:0] EVT_SYN = 16'h0000;
  localparam logic [EVT_W-1:0] EVT_KEY = 16'h0001;
  localparam logic [EVT_W-1:0] EVT_ABS = 16'h0003;

  // event codes
  localparam logic [EVT_W-1:0] CODE_ABS_X      = 16'h0000;
  localparam logic [EVT_W-1:0] CODE_ABS_Y      = 16'h0001;
  localparam logic [EVT_W-1:0] CODE_MT_SLOT    = 16'h002F;
  localparam logic [EVT_W-1:0] CODE_MT_POS_X   = 16'h0035;
  localparam logic [EVT_W-1:0] CODE_MT_POS_Y   = 16'h0036;
  localparam logic [EVT_W-1:0] CODE_MT_TRACK   = 16'h0039;
  localparam logic [EVT_W-1:0] CODE_BTN_LEFT   = 16'h0110;
  localparam logic [EVT_W-1:0] CODE_BTN_TOUCH  = 16'h014A;
  localparam logic [EVT_W-1:0] CODE_SYN_REPORT = 16'h0000;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_X_MIN       = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_X_MAX       = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_MIN       = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_MAX       = 8'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SCR_WIDTH   = 8'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SCR_HEIGHT  = 8'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIENTATION = 8'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_TOUCH_MODE  = 8'd7;

  // touch modes
  localparam logic [MODE_W-1:0] MODE_LEGACY = 5'd0;
  localparam logic [MODE_W-1:0] MODE_SLOTTED_MIN = 5'd2;

  // orientation bits
  localparam int OR_SWAP  = 0;
  localparam int OR_INV_X = 1;
  localparam int OR_INV_Y = 2;

  // axis scaler states
  typedef enum logic [1:0] {
    SC_IDLE,
    SC_CHECK,
    SC_MUL,
    SC_DIV
  } sc_state_t;

  // top level sequencer states
  typedef enum logic [1:0] {
    TS_IDLE,
    TS_SCALE,
    TS_SCAN,
    TS_EMIT
  } top_state_t;

  // commands to the slot store
  typedef struct packed {
    logic clear;
    logic legacy;
    logic set_slot;
    logic wr_act_cs;
    logic wr_act_0;
    logic act_val;
    logic wr_x;
    logic wr_y;
    logic scan_start;
  } st_cmd_t;

  // status from the slot store
  typedef struct packed {
    logic done;
    logic found;
  } st_sts_t;

endpackage
`default_nettype wire

// File: rtl/mtp_intf.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mtp_intf
// Valid/ready channels of the block: input events, pointer results and
// configuration writes.
// ----------------------------------------------------------------------------

// input event channel
interface mtp_evt_if import mtp_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [EVT_W-1:0]        event_type;
  logic [EVT_W-1:0]        event_code;
  logic signed [VAL_W-1:0] event_value;

  modport source (output valid, output event_type, output event_code,
                  output event_value, input ready);
  modport sink   (input valid, input event_type, input event_code,
                  input event_value, output ready);
endinterface

// pointer result channel
interface mtp_ptr_if import mtp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [POS_W-1:0] pos_x;
  logic [POS_W-1:0] pos_y;
  logic             pressed;

  modport source (output valid, output pos_x, output pos_y, output pressed,
                  input ready);
  modport sink   (input valid, input pos_x, input pos_y, input pressed,
                  output ready);
endinterface

// configuration write channel
interface mtp_cfg_if import mtp_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [VAL_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/mtp_axis_scaler.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mtp_axis_scaler
// Clamps a raw axis value to its range and scales it to screen pixels with
// fraction bits: a bit-serial shift-add multiply followed by a bit-serial
// restoring divide, one bit per cycle each.
// ----------------------------------------------------------------------------
module mtp_axis_scaler import mtp_pkg::*; #(
  parameter int FRAC_BITS = 4
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [VAL_W-1:0] value,
  input  logic signed [VAL_W-1:0] lo,
  input  logic signed [VAL_W-1:0] hi,
  input  logic [SIZE_W-1:0]       size,
  output logic                    done,
  output logic [POS_W-1:0]        res
);

  localparam int FULL_W = SIZE_W + FRAC_BITS;
  localparam int ACC_W  = VAL_W + FULL_W;
  localparam int CNT_W  = $clog2(FULL_W);
  localparam int EXT_W  = (FULL_W > POS_W) ? FULL_W : POS_W;

  sc_state_t          state_r, state_nxt;
  logic [VAL_W:0]     d_r, d_nxt;
  logic [VAL_W:0]     r_r, r_nxt;
  logic [FULL_W-1:0]  full_r, full_nxt;
  logic [ACC_W-1:0]   acc_r, acc_nxt;
  logic [VAL_W-1:0]   rem_r, rem_nxt;
  logic [FULL_W-1:0]  quo_r, quo_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               done_r, done_nxt;
  logic [POS_W-1:0]   res_r, res_nxt;

  logic [ACC_W-1:0]   mul_sum;
  logic [VAL_W:0]     trial;
  logic [VAL_W:0]     diff;
  logic               ge;
  logic [FULL_W-1:0]  quo_step;

  // saturate a scaled value to the output width
  function automatic logic [POS_W-1:0] sat_pos(input logic [FULL_W-1:0] v);
    logic [EXT_W-1:0] ext;
    ext = EXT_W'(v);
    if (ext > EXT_W'(POS_MAX)) begin
      return POS_MAX;
    end
    return ext[POS_W-1:0];
  endfunction

  // one multiply step and one divide step
  always_comb begin
    mul_sum  = (acc_r << 1) + (full_r[FULL_W-1] ? ACC_W'(d_r[VAL_W-1:0]) : '0);
    trial    = {rem_r, quo_r[FULL_W-1]};
    diff     = trial - {1'b0, r_r[VAL_W-1:0]};
    ge       = (trial >= {1'b0, r_r[VAL_W-1:0]});
    quo_step = {quo_r[FULL_W-2:0], ge};
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    d_nxt     = d_r;
    r_nxt     = r_r;
    full_nxt  = full_r;
    acc_nxt   = acc_r;
    rem_nxt   = rem_r;
    quo_nxt   = quo_r;
    cnt_nxt   = cnt_r;
    done_nxt  = 1'b0;
    res_nxt   = res_r;
    unique case (state_r)
      SC_IDLE: begin
        if (start) begin
          d_nxt     = {value[VAL_W-1], value} - {lo[VAL_W-1], lo};
          r_nxt     = {hi[VAL_W-1], hi} - {lo[VAL_W-1], lo};
          full_nxt  = FULL_W'(size) << FRAC_BITS;
          state_nxt = SC_CHECK;
        end
      end
      SC_CHECK: begin
        if (r_r[VAL_W] || (r_r == '0) || d_r[VAL_W] || (d_r == '0)) begin
          res_nxt   = '0;
          done_nxt  = 1'b1;
          state_nxt = SC_IDLE;
        end else if (d_r >= r_r) begin
          res_nxt   = sat_pos(full_r);
          done_nxt  = 1'b1;
          state_nxt = SC_IDLE;
        end else begin
          acc_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = SC_MUL;
        end
      end
      SC_MUL: begin
        acc_nxt  = mul_sum;
        full_nxt = full_r << 1;
        cnt_nxt  = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(FULL_W - 1)) begin
          // high part of the product is already below the range
          rem_nxt   = mul_sum[ACC_W-1 -: VAL_W];
          quo_nxt   = mul_sum[FULL_W-1:0];
          cnt_nxt   = '0;
          state_nxt = SC_DIV;
        end
      end
      SC_DIV: begin
        rem_nxt = ge ? diff[VAL_W-1:0] : trial[VAL_W-1:0];
        quo_nxt = quo_step;
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(FULL_W - 1)) begin
          res_nxt   = sat_pos(quo_step);
          done_nxt  = 1'b1;
          state_nxt = SC_IDLE;
        end
      end
      default: state_nxt = SC_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SC_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    d_r    <= d_nxt;
    r_r    <= r_nxt;
    full_r <= full_nxt;
    acc_r  <= acc_nxt;
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    cnt_r  <= cnt_nxt;
    res_r  <= res_nxt;
  end

  assign done = done_r;
  assign res  = res_r;

endmodule
`default_nettype wire

// File: rtl/mtp_slot_store.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mtp_slot_store
// Per-slot contact flags and positions, the current slot pointer, and a serial
// scan that reads out the first active slot's position, or the current slot's.
// ----------------------------------------------------------------------------
module mtp_slot_store import mtp_pkg::*; #(
  parameter int SLOTS = 16
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  st_cmd_t                                  cmd,
  input  logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] slot_val,
  input  logic [(($clog2(SLOTS + 1) > MODE_W) ? $clog2(SLOTS + 1) : MODE_W)-1:0]
                                                   slot_cnt,
  input  logic [POS_W-1:0]                         pos,
  output st_sts_t                                  sts,
  output logic [POS_W-1:0]                         rd_x,
  output logic [POS_W-1:0]                         rd_y
);

  localparam int SW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int SC_W = ($clog2(SLOTS + 1) > MODE_W) ? $clog2(SLOTS + 1) : MODE_W;

  logic [SW-1:0]    cur_r, cur_nxt;
  logic [SLOTS-1:0] act_r, act_nxt;
  logic [SLOTS-1:0] xv_r, xv_nxt;
  logic [SLOTS-1:0] yv_r, yv_nxt;
  logic [POS_W-1:0] x_r [SLOTS];
  logic [POS_W-1:0] y_r [SLOTS];

  logic             busy_r, busy_nxt;
  logic             rdp_r, rdp_nxt;
  logic [SW-1:0]    idx_r, idx_nxt;
  logic [SW-1:0]    rs_r, rs_nxt;
  logic             found_r, found_nxt;
  logic             done_r;
  logic [POS_W-1:0] rd_x_r, rd_y_r;
  logic             scan_last;

  assign scan_last = ((SC_W'(idx_r) + SC_W'(1)) == slot_cnt);

  // slot pointer, flags and valid bits
  always_comb begin
    cur_nxt = cur_r;
    act_nxt = act_r;
    xv_nxt  = xv_r;
    yv_nxt  = yv_r;
    if (cmd.clear) begin
      cur_nxt    = '0;
      act_nxt    = '0;
      act_nxt[0] = cmd.legacy;
      xv_nxt     = '0;
      yv_nxt     = '0;
    end else begin
      if (cmd.set_slot) begin
        cur_nxt = slot_val;
      end
      if (cmd.wr_act_cs) begin
        act_nxt[cur_r] = cmd.act_val;
      end else if (cmd.wr_act_0) begin
        act_nxt[0] = cmd.act_val;
      end
      if (cmd.wr_x) begin
        xv_nxt[cur_r] = 1'b1;
      end
      if (cmd.wr_y) begin
        yv_nxt[cur_r] = 1'b1;
      end
    end
  end

  // first active slot scan, one slot per cycle
  always_comb begin
    busy_nxt  = busy_r;
    rdp_nxt   = 1'b0;
    idx_nxt   = idx_r;
    rs_nxt    = rs_r;
    found_nxt = found_r;
    if (cmd.scan_start) begin
      busy_nxt = 1'b1;
      idx_nxt  = '0;
    end else if (busy_r) begin
      if (act_r[idx_r]) begin
        rs_nxt    = idx_r;
        found_nxt = 1'b1;
        busy_nxt  = 1'b0;
        rdp_nxt   = 1'b1;
      end else if (scan_last) begin
        rs_nxt    = cur_r;
        found_nxt = 1'b0;
        busy_nxt  = 1'b0;
        rdp_nxt   = 1'b1;
      end else begin
        idx_nxt = idx_r + SW'(1);
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r   <= '0;
      act_r   <= '0;
      xv_r    <= '0;
      yv_r    <= '0;
      busy_r  <= 1'b0;
      rdp_r   <= 1'b0;
      done_r  <= 1'b0;
      found_r <= 1'b0;
    end else begin
      cur_r   <= cur_nxt;
      act_r   <= act_nxt;
      xv_r    <= xv_nxt;
      yv_r    <= yv_nxt;
      busy_r  <= busy_nxt;
      rdp_r   <= rdp_nxt;
      done_r  <= rdp_r;
      found_r <= found_nxt;
    end
  end

  // position arrays, an entry without its valid bit reads as zero
  always_ff @(posedge clk) begin
    if (cmd.wr_x) begin
      x_r[cur_r] <= pos;
    end
    if (cmd.wr_y) begin
      y_r[cur_r] <= pos;
    end
    idx_r <= idx_nxt;
    rs_r  <= rs_nxt;
    if (rdp_r) begin
      rd_x_r <= xv_r[rs_r] ? x_r[rs_r] : '0;
      rd_y_r <= yv_r[rs_r] ? y_r[rs_r] : '0;
    end
  end

  assign sts.done  = done_r;
  assign sts.found = found_r;
  assign rd_x      = rd_x_r;
  assign rd_y      = rd_y_r;

endmodule
`default_nettype wire

// File: rtl/multitouch_event_to_pointer_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// multitouch_event_to_pointer_unit
// Turns touch input events into a single pointer with position and press
// state, one pointer item on each sync report.
//
//   channel  dir  handshake     payload
//   in_ch    in   valid/ready   event_type, event_code, event_value
//   out_ch   out  valid/ready   pos_x, pos_y, pressed
//   cfg_ch   in   valid/ready   index, data (always ready)
//
// Axis items go through the multiply and divide of the bit-serial scaler; a
// value at or past either end of the range, or an empty range, skips both.
// A sync report runs the slot scan, read and emit, plus any wait for the
// output register to free up. All other items are taken in the idle state
// without a stall. Synchronous active-low reset; a touch mode write clears
// the slot store.
// ----------------------------------------------------------------------------
module multitouch_event_to_pointer_unit import mtp_pkg::*; #(
  parameter int SLOTS     = 16,
  parameter int FRAC_BITS = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  mtp_evt_if.sink    in_ch,
  mtp_ptr_if.source  out_ch,
  mtp_cfg_if.sink    cfg_ch
);

  localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int SC_W  = ($clog2(SLOTS + 1) > MODE_W) ? $clog2(SLOTS + 1) : MODE_W;
  localparam int FULL_W = SIZE_W + FRAC_BITS;
  localparam int INV_W = ((FULL_W > POS_W) ? FULL_W : POS_W) + 1;

  // configuration registers
  logic signed [VAL_W-1:0] x_min_r, x_max_r, y_min_r, y_max_r;
  logic [SIZE_W-1:0]       width_r, height_r;
  logic [ORIENT_W-1:0]     orient_r;
  logic [MODE_W-1:0]       mode_r;

  top_state_t        state_r, state_nxt;
  logic              axis_y_r, axis_y_nxt;
  logic              button_r, button_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [POS_W-1:0]  out_x_r, out_x_nxt;
  logic [POS_W-1:0]  out_y_r, out_y_nxt;
  logic              out_p_r, out_p_nxt;

  logic              cfg_we;
  logic              mode_we;
  logic              has_slots;
  logic [EVT_W-1:0]  xcode, ycode;
  logic [SC_W-1:0]   slot_cnt;
  logic [SC_W-1:0]   mode_less1;
  logic              slot_ok;
  logic              val_nonneg;
  logic              val_nz;
  logic              swap;

  st_cmd_t           st_cmd;
  st_sts_t           st_sts;
  logic [POS_W-1:0]  rd_x, rd_y;

  logic              sc_start;
  logic              sc_done;
  logic [POS_W-1:0]  sc_res;
  logic              use_height;
  logic [POS_W-1:0]  px, py;

  // mirror a position against the screen edge, clamped at zero
  function automatic logic [POS_W-1:0] inv_pos(input logic [SIZE_W-1:0] sz,
                                               input logic [POS_W-1:0]  p);
    logic [INV_W-1:0] full;
    logic [INV_W-1:0] pe;
    logic [INV_W-1:0] d;
    full = INV_W'(sz) << FRAC_BITS;
    pe   = INV_W'(p);
    d    = full - pe;
    if (pe > full) begin
      return '0;
    end
    return d[POS_W-1:0];
  endfunction

  assign cfg_ch.ready = 1'b1;
  assign cfg_we       = cfg_ch.valid;
  assign mode_we      = cfg_we && (cfg_ch.index == CFG_TOUCH_MODE);

  // register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_min_r  <= '0;
      x_max_r  <= 32'sd4095;
      y_min_r  <= '0;
      y_max_r  <= 32'sd4095;
      width_r  <= 13'd1080;
      height_r <= 13'd2400;
      orient_r <= '0;
      mode_r   <= 5'd17;
    end else if (cfg_we) begin
      unique case (cfg_ch.index)
        CFG_X_MIN:       x_min_r  <= cfg_ch.data;
        CFG_X_MAX:       x_max_r  <= cfg_ch.data;
        CFG_Y_MIN:       y_min_r  <= cfg_ch.data;
        CFG_Y_MAX:       y_max_r  <= cfg_ch.data;
        CFG_SCR_WIDTH:   width_r  <= cfg_ch.data[SIZE_W-1:0];
        CFG_SCR_HEIGHT:  height_r <= cfg_ch.data[SIZE_W-1:0];
        CFG_ORIENTATION: orient_r <= cfg_ch.data[ORIENT_W-1:0];
        CFG_TOUCH_MODE:  mode_r   <= cfg_ch.data[MODE_W-1:0];
        default: ;
      endcase
    end
  end

  // mode-derived decode values
  always_comb begin
    has_slots  = (mode_r >= MODE_SLOTTED_MIN);
    xcode      = (mode_r == MODE_LEGACY) ? CODE_ABS_X : CODE_MT_POS_X;
    ycode      = (mode_r == MODE_LEGACY) ? CODE_ABS_Y : CODE_MT_POS_Y;
    mode_less1 = SC_W'(mode_r) - SC_W'(1);
    if (!has_slots) begin
      slot_cnt = SC_W'(1);
    end else if (mode_less1 > SC_W'(SLOTS)) begin
      slot_cnt = SC_W'(SLOTS);
    end else begin
      slot_cnt = mode_less1;
    end
    val_nonneg = !in_ch.event_value[VAL_W-1];
    val_nz     = |in_ch.event_value;
    slot_ok    = val_nonneg &&
                 (in_ch.event_value[VAL_W-2:0] < (VAL_W-1)'(slot_cnt));
    swap       = orient_r[OR_SWAP];
    use_height = axis_y_nxt ^ swap;
  end

  // pointer orientation on the read slot
  always_comb begin
    px = swap ? rd_y : rd_x;
    py = swap ? rd_x : rd_y;
    if (orient_r[OR_INV_X]) begin
      px = inv_pos(width_r, px);
    end
    if (orient_r[OR_INV_Y]) begin
      py = inv_pos(height_r, py);
    end
  end

  // item sequencer
  always_comb begin
    state_nxt     = state_r;
    axis_y_nxt    = axis_y_r;
    button_nxt    = button_r;
    out_valid_nxt = out_valid_r;
    out_x_nxt     = out_x_r;
    out_y_nxt     = out_y_r;
    out_p_nxt     = out_p_r;
    sc_start      = 1'b0;
    st_cmd        = '0;
    st_cmd.clear  = mode_we;
    st_cmd.legacy = (cfg_ch.data[MODE_W-1:0] == MODE_LEGACY);

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      TS_IDLE: begin
        if (in_ch.valid) begin
          if (in_ch.event_type == EVT_ABS) begin
            if ((in_ch.event_code == CODE_MT_SLOT) && has_slots) begin
              st_cmd.set_slot = slot_ok;
            end else if ((in_ch.event_code == CODE_MT_TRACK) && has_slots) begin
              st_cmd.wr_act_cs = 1'b1;
              st_cmd.act_val   = val_nonneg;
            end else if (in_ch.event_code == xcode) begin
              sc_start   = 1'b1;
              axis_y_nxt = 1'b0;
              state_nxt  = TS_SCALE;
            end else if (in_ch.event_code == ycode) begin
              sc_start   = 1'b1;
              axis_y_nxt = 1'b1;
              state_nxt  = TS_SCALE;
            end else if (in_ch.event_code == CODE_MT_TRACK) begin
              st_cmd.wr_act_0 = 1'b1;
              st_cmd.act_val  = val_nonneg;
            end
          end else if ((in_ch.event_type == EVT_KEY) &&
                       ((in_ch.event_code == CODE_BTN_TOUCH) ||
                        (in_ch.event_code == CODE_BTN_LEFT))) begin
            button_nxt = val_nz;
            if (!has_slots) begin
              st_cmd.wr_act_0 = 1'b1;
              st_cmd.act_val  = val_nz;
            end
          end else if ((in_ch.event_type == EVT_SYN) &&
                       (in_ch.event_code == CODE_SYN_REPORT)) begin
            st_cmd.scan_start = 1'b1;
            state_nxt         = TS_SCAN;
          end
        end
      end
      TS_SCALE: begin
        if (sc_done) begin
          st_cmd.wr_x = !axis_y_r;
          st_cmd.wr_y = axis_y_r;
          state_nxt   = TS_IDLE;
        end
      end
      TS_SCAN: begin
        if (st_sts.done) begin
          state_nxt = TS_EMIT;
        end
      end
      TS_EMIT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_x_nxt     = px;
          out_y_nxt     = py;
          out_p_nxt     = st_sts.found || button_r;
          state_nxt     = TS_IDLE;
        end
      end
      default: state_nxt = TS_IDLE;
    endcase

    if (mode_we) begin
      button_nxt = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= TS_IDLE;
      button_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      button_r    <= button_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    axis_y_r <= axis_y_nxt;
    out_x_r  <= out_x_nxt;
    out_y_r  <= out_y_nxt;
    out_p_r  <= out_p_nxt;
  end

  assign in_ch.ready    = (state_r == TS_IDLE);
  assign out_ch.valid   = out_valid_r;
  assign out_ch.pos_x   = out_x_r;
  assign out_ch.pos_y   = out_y_r;
  assign out_ch.pressed = out_p_r;

  // bit-serial axis scaler
  mtp_axis_scaler #(
    .FRAC_BITS (FRAC_BITS)
  ) u_scaler (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sc_start),
    .value (in_ch.event_value),
    .lo    (axis_y_nxt ? y_min_r : x_min_r),
    .hi    (axis_y_nxt ? y_max_r : x_max_r),
    .size  (use_height ? height_r : width_r),
    .done  (sc_done),
    .res   (sc_res)
  );

  // slot store with serial scan
  mtp_slot_store #(
    .SLOTS (SLOTS)
  ) u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (st_cmd),
    .slot_val (in_ch.event_value[SW-1:0]),
    .slot_cnt (slot_cnt),
    .pos      (sc_res),
    .sts      (st_sts),
    .rd_x     (rd_x),
    .rd_y     (rd_y)
  );

endmodule
`default_nettype wire
